@@ hw/rtl/servo_bus_packet_framer_core_defines.svh @@
// assertion macros shared by the servo bus framer checker
`ifndef SERVO_BUS_PACKET_FRAMER_CORE_DEFINES_SVH
`define SERVO_BUS_PACKET_FRAMER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define SBPF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbpf: check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define SBPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbpf: check failed");

`endif

@@ hw/rtl/sbpf_pkg.sv @@
// shared types and constants of the servo bus packet framer
package sbpf_pkg;

  localparam int unsigned MAX_ENTRIES = 32;
  localparam int unsigned BODY_MAX    = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] HDR_BYTE      = 8'hFF;
  localparam logic [7:0] BCAST_ID      = 8'hFE;
  localparam logic [7:0] INS_PING      = 8'h01;
  localparam logic [7:0] INS_READ      = 8'h02;
  localparam logic [7:0] INS_WRITE     = 8'h03;
  localparam logic [7:0] INS_REGWRITE  = 8'h04;
  localparam logic [7:0] INS_ACTION    = 8'h05;
  localparam logic [7:0] INS_FRESET    = 8'h06;
  localparam logic [7:0] INS_REBOOT    = 8'h08;
  localparam logic [7:0] INS_SYNC      = 8'h83;
  localparam logic [7:0] INS_BULK      = 8'h92;
  localparam logic [7:0] LEN_SHORT     = 8'h02;
  localparam logic [7:0] LEN_READ      = 8'h04;
  localparam logic [7:0] LEN_WRITE     = 8'h05;
  localparam logic [7:0] SYNC_LEN_BASE = 8'h04;
  localparam logic [7:0] BULK_LEN_BASE = 8'h03;
  localparam logic [7:0] BULK_PAD      = 8'h00;
  localparam logic [2:0] SYNC_SIZE_MAX = 3'd4;

  typedef enum logic [3:0] {
    OP_PING        = 4'd0,
    OP_READ        = 4'd1,
    OP_WRITE       = 4'd2,
    OP_REGWRITE    = 4'd3,
    OP_ACTION      = 4'd4,
    OP_FRESET      = 4'd5,
    OP_REBOOT      = 4'd6,
    OP_SYNC_START  = 4'd7,
    OP_SYNC_ENTRY  = 4'd8,
    OP_BULK_START  = 4'd9,
    OP_BULK_ENTRY  = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    GRP_NONE = 2'd0,
    GRP_SYNC = 2'd1,
    GRP_BULK = 2'd2
  } grp_t;

  // one queued job: byte list plus how to finish it
  typedef struct packed {
    logic                      err;     // single error result
    logic                      clr;     // restart the running checksum
    logic                      chk;     // append checksum after the bytes
    logic                      hdr;     // first two bytes are header, not summed
    logic [3:0]                nbytes;  // bytes in the list
    logic [BODY_MAX-1:0][7:0]  bytes;
  } desc_t;

endpackage

@@ hw/rtl/sbpf_front.sv @@
// front end: takes command transfers, tracks open groups, builds byte jobs
module sbpf_front
  import sbpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [3:0]  op,
  input  logic [7:0]  servo_id,
  input  logic [7:0]  reg_address,
  input  logic [31:0] value,
  input  logic [7:0]  length,
  input  logic [7:0]  entry_count,
  input  logic        q_full,
  output logic        push,
  output desc_t       push_desc
);

  grp_t       group_mode, group_mode_next;
  logic [7:0] entries_left, entries_left_next;
  logic [2:0] sync_data_size, sync_data_size_next;

  logic [7:0]  left_dec;
  logic [7:0]  sync_prod;
  logic [7:0]  sync_len;
  logic [7:0]  bulk_len;
  logic        cnt_bad;
  logic        size_bad;
  logic [7:0]  short_ins;

  assign cmd_stall = q_full;
  assign push      = cmd_valid && !q_full;

  assign left_dec  = entries_left - 8'd1;
  assign sync_prod = entry_count * (8'(length[2:0]) + 8'd1);
  assign sync_len  = SYNC_LEN_BASE + sync_prod;
  assign bulk_len  = BULK_LEN_BASE + entry_count + {entry_count[6:0], 1'b0};
  assign cnt_bad   = (entry_count == 8'd0) || (entry_count > 8'(MAX_ENTRIES));
  assign size_bad  = (length == 8'd0) || (length > 8'(SYNC_SIZE_MAX));

  always_comb begin
    unique case (op)
      OP_PING:   short_ins = INS_PING;
      OP_ACTION: short_ins = INS_ACTION;
      OP_FRESET: short_ins = INS_FRESET;
      default:   short_ins = INS_REBOOT;
    endcase
  end

  always_comb begin
    push_desc           = '0;
    group_mode_next     = group_mode;
    entries_left_next   = entries_left;
    sync_data_size_next = sync_data_size;

    // any defined command but an entry abandons an open group
    if (op != OP_SYNC_ENTRY && op != OP_BULK_ENTRY && op <= OP_BULK_ENTRY) begin
      group_mode_next     = GRP_NONE;
      entries_left_next   = 8'd0;
      sync_data_size_next = 3'd0;
      push_desc.clr       = 1'b1;
    end

    unique case (op)
      OP_PING, OP_ACTION, OP_FRESET, OP_REBOOT: begin
        push_desc.hdr      = 1'b1;
        push_desc.chk      = 1'b1;
        push_desc.nbytes   = 4'd5;
        push_desc.bytes[0] = HDR_BYTE;
        push_desc.bytes[1] = HDR_BYTE;
        push_desc.bytes[2] = servo_id;
        push_desc.bytes[3] = LEN_SHORT;
        push_desc.bytes[4] = short_ins;
      end
      OP_READ: begin
        push_desc.hdr      = 1'b1;
        push_desc.chk      = 1'b1;
        push_desc.nbytes   = 4'd7;
        push_desc.bytes[0] = HDR_BYTE;
        push_desc.bytes[1] = HDR_BYTE;
        push_desc.bytes[2] = servo_id;
        push_desc.bytes[3] = LEN_READ;
        push_desc.bytes[4] = INS_READ;
        push_desc.bytes[5] = reg_address;
        push_desc.bytes[6] = length;
      end
      OP_WRITE, OP_REGWRITE: begin
        push_desc.hdr      = 1'b1;
        push_desc.chk      = 1'b1;
        push_desc.nbytes   = 4'd8;
        push_desc.bytes[0] = HDR_BYTE;
        push_desc.bytes[1] = HDR_BYTE;
        push_desc.bytes[2] = servo_id;
        push_desc.bytes[3] = LEN_WRITE;
        push_desc.bytes[4] = (op == OP_WRITE) ? INS_WRITE : INS_REGWRITE;
        push_desc.bytes[5] = reg_address;
        push_desc.bytes[6] = value[7:0];
        push_desc.bytes[7] = value[15:8];
      end
      OP_SYNC_START: begin
        if (cnt_bad || size_bad) begin
          push_desc.err = 1'b1;
        end else begin
          push_desc.hdr       = 1'b1;
          push_desc.nbytes    = 4'd7;
          push_desc.bytes[0]  = HDR_BYTE;
          push_desc.bytes[1]  = HDR_BYTE;
          push_desc.bytes[2]  = BCAST_ID;
          push_desc.bytes[3]  = sync_len;
          push_desc.bytes[4]  = INS_SYNC;
          push_desc.bytes[5]  = reg_address;
          push_desc.bytes[6]  = length;
          group_mode_next     = GRP_SYNC;
          entries_left_next   = entry_count;
          sync_data_size_next = length[2:0];
        end
      end
      OP_BULK_START: begin
        if (cnt_bad) begin
          push_desc.err = 1'b1;
        end else begin
          push_desc.hdr      = 1'b1;
          push_desc.nbytes   = 4'd6;
          push_desc.bytes[0] = HDR_BYTE;
          push_desc.bytes[1] = HDR_BYTE;
          push_desc.bytes[2] = BCAST_ID;
          push_desc.bytes[3] = bulk_len;
          push_desc.bytes[4] = INS_BULK;
          push_desc.bytes[5] = BULK_PAD;
          group_mode_next    = GRP_BULK;
          entries_left_next  = entry_count;
        end
      end
      OP_SYNC_ENTRY, OP_BULK_ENTRY: begin
        if ((op == OP_SYNC_ENTRY && group_mode != GRP_SYNC) ||
            (op == OP_BULK_ENTRY && group_mode != GRP_BULK) ||
            entries_left == 8'd0) begin
          push_desc.err = 1'b1;
        end else begin
          if (op == OP_SYNC_ENTRY) begin
            push_desc.nbytes   = 4'({1'b0, sync_data_size}) + 4'd1;
            push_desc.bytes[0] = servo_id;
            push_desc.bytes[1] = value[7:0];
            push_desc.bytes[2] = value[15:8];
            push_desc.bytes[3] = value[23:16];
            push_desc.bytes[4] = value[31:24];
          end else begin
            push_desc.nbytes   = 4'd3;
            push_desc.bytes[0] = length;
            push_desc.bytes[1] = servo_id;
            push_desc.bytes[2] = reg_address;
          end
          entries_left_next = left_dec;
          // final entry closes the packet
          if (left_dec == 8'd0) begin
            push_desc.chk       = 1'b1;
            group_mode_next     = GRP_NONE;
            sync_data_size_next = 3'd0;
          end
        end
      end
      default: begin
        push_desc.err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_mode     <= GRP_NONE;
      entries_left   <= 8'd0;
      sync_data_size <= 3'd0;
    end else if (push) begin
      group_mode     <= group_mode_next;
      entries_left   <= entries_left_next;
      sync_data_size <= sync_data_size_next;
    end
  end

endmodule

@@ hw/rtl/sbpf_queue.sv @@
// short job queue between the front and back ends
module sbpf_queue
  import sbpf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  output logic  q_full,
  output logic  q_valid,
  output desc_t q_head,
  input  logic  pop
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  desc_t            slots [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  fill;

  assign q_full  = (fill == CntW'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/sbpf_back.sv @@
// back end: plays out queued jobs one byte per cycle unless rsp_stall holds the output, and keeps the checksum
module sbpf_back
  import sbpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  desc_t      q_head,
  output logic       pop,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       packet_end,
  output logic       error
);

  desc_t      cur;
  logic       busy, busy_next;
  logic [3:0] idx, idx_next;
  logic [7:0] sum, sum_next;

  logic       advance;
  logic       emit;
  logic       in_body;
  logic       summed;
  logic [7:0] byte_sel;
  logic [7:0] sum_emit;
  logic [7:0] e_byte;
  logic       e_last;
  logic       e_end;
  logic       e_err;

  assign advance  = !rsp_valid || !rsp_stall;
  assign emit     = busy && advance;
  assign in_body  = idx < cur.nbytes;
  assign summed   = !cur.hdr || (idx[3:1] != 3'd0);
  assign byte_sel = cur.bytes[idx[2:0]];

  always_comb begin
    e_byte   = 8'd0;
    e_last   = 1'b1;
    e_end    = 1'b0;
    e_err    = 1'b0;
    sum_emit = sum;
    if (cur.err) begin
      e_err = 1'b1;
    end else if (in_body) begin
      e_byte   = byte_sel;
      e_last   = (idx == cur.nbytes - 4'd1) && !cur.chk;
      sum_emit = summed ? sum + byte_sel : sum;
    end else begin
      e_byte   = ~sum;
      e_end    = 1'b1;
      sum_emit = 8'd0;
    end
  end

  assign pop = q_valid && (!busy || (emit && e_last));

  always_comb begin
    busy_next = busy;
    idx_next  = idx;
    sum_next  = emit ? sum_emit : sum;
    if (pop) begin
      busy_next = 1'b1;
      idx_next  = 4'd0;
      if (q_head.clr) begin
        sum_next = 8'd0;
      end
    end else if (emit) begin
      busy_next = !e_last;
      idx_next  = idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 4'd0;
      sum       <= 8'd0;
      rsp_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      idx  <= idx_next;
      sum  <= sum_next;
      if (advance) begin
        rsp_valid <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    if (emit) begin
      out_byte   <= e_byte;
      run_last   <= e_last;
      packet_end <= e_end;
      error      <= e_err;
    end
  end

endmodule

@@ hw/rtl/servo_bus_packet_framer_core.sv @@
// top level of the servo bus instruction packet framer
// a command is written into the job queue, loaded as the back end's current job, then its first byte is registered out
// throughput: one result byte per cycle while rsp_stall is low; how long an item holds the output
//   is set by its byte count, since the back end plays out one byte per cycle
// a 2-entry job queue lets the next command transfer while bytes still drain
// reset (rst, synchronous) closes any open group, zeroes the checksum, empties the queue
module servo_bus_packet_framer_core
  import sbpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [3:0]  op,
  input  logic [7:0]  servo_id,
  input  logic [7:0]  reg_address,
  input  logic [31:0] value,
  input  logic [7:0]  length,
  input  logic [7:0]  entry_count,
  // packet byte channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        packet_end,
  output logic        error
);

  // front to queue
  logic  push;
  desc_t push_desc;
  logic  q_full;

  // queue to back
  logic  q_valid;
  desc_t q_head;
  logic  pop;

  // front end decodes the command, owns group state, and forms a byte job
  sbpf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .op          (op),
    .servo_id    (servo_id),
    .reg_address (reg_address),
    .value       (value),
    .length      (length),
    .entry_count (entry_count),
    .q_full      (q_full),
    .push        (push),
    .push_desc   (push_desc)
  );

  // jobs wait here so a stalled byte stream does not block command transfers
  sbpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop)
  );

  // back end serializes jobs; running checksum spans the entries of a group
  sbpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .packet_end (packet_end),
    .error      (error)
  );

endmodule

@@ hw/rtl/sbpf_checker.sv @@
// port-level checks for the servo bus framer, bound to the top level
`include "servo_bus_packet_framer_core_defines.svh"

module sbpf_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       packet_end,
  input logic       error
);

  // a stalled byte holds
  `SBPF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(out_byte) && $stable(run_last) && $stable(packet_end) && $stable(error))

  // an error result is a single zero byte
  `SBPF_ASSERT_NOW(a_err_shape, rsp_valid && error, run_last && !packet_end && out_byte == 8'd0)

  // the checksum always closes its item
  `SBPF_ASSERT_NOW(a_end_last, rsp_valid && packet_end, run_last && !error)

  // bytes of one item follow without gaps
  `SBPF_ASSERT_NEXT(a_no_gap, rsp_valid && !rsp_stall && !run_last, rsp_valid)

endmodule

bind servo_bus_packet_framer_core sbpf_checker u_sbpf_checker (.*);
